>>> hdl/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg
// shared types and constants for the block-walk position id generator
// ----------------------------------------------------------------------------
package mbp_pkg;

    // fixed field widths
    localparam int DIM_W    = 11;   // frames, height, width
    localparam int POS_W    = 10;   // row and column position ids
    localparam int FLAT_W   = 21;   // position inside one frame
    localparam int MREG_W   = 4;    // merge size register
    localparam int AREA_W   = 2 * DIM_W;

    // height and width saturate here on load
    localparam int MAX_GRID = 1024;

    // cycles from a dimension or merge size change until the geometry is valid
    localparam int GEOM_LAT = 3;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [DIM_W-1:0] img_frames;
        logic [DIM_W-1:0] img_height;
        logic [DIM_W-1:0] img_width;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] pos_row;
        logic [POS_W-1:0] pos_col;
        logic             last_of_image;
    } t_out_item;

    // derived grid geometry
    typedef struct packed {
        logic [DIM_W-1:0]  nwb;     // whole blocks across
        logic [AREA_W-1:0] region;  // positions covered by whole blocks
        logic [AREA_W-1:0] grid;    // positions per frame
    } t_geom;

endpackage

>>> hdl/merge_block_position_ids_top.sv
// ----------------------------------------------------------------------------
// merge_block_position_ids_top
// 2-d row/column position ids for a patch grid walked in square merge blocks
// ----------------------------------------------------------------------------
// A load item (cmd 0) latches frames, height and width (height and width
// saturate at 1024) and restarts the walk; it gives no result. Each next item
// (cmd 1) gives one (pos_row, pos_col) pair while an image is active: blocks of
// merge_size x merge_size go in row-major order, rows then columns inside a
// block, and positions outside the whole blocks come out as (0,0). The frame
// sequence repeats once per frame and last_of_image marks the final pair,
// after which next items are dropped until the next load. Rate: next items
// are taken one per clock unless the output stalls or the geometry settles.
// After a load is processed, or after a merge_size write, the block serves no
// item (o_in_stall rises once one waits) and drops o_cfg_ready while the
// three-stage geometry pipeline (reciprocal multiply, block extent, block
// region area) settles. merge_size 0 acts as 1, above MAX_MERGE as MAX_MERGE.
// ----------------------------------------------------------------------------
module merge_block_position_ids_top #(
    parameter int MAX_MERGE = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // item input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  mbp_pkg::t_in_item          i_in_data,
    // result output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output mbp_pkg::t_out_item         o_out_data,
    // merge_size register write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [mbp_pkg::MREG_W-1:0] i_cfg_data
);
    import mbp_pkg::*;

    localparam int MERGE_W = $clog2(MAX_MERGE + 1);
    localparam int LAT_W   = $clog2(GEOM_LAT + 1);

    // input register
    logic               r_in_vld;
    t_in_item           r_in;
    // merge size register and geometry settle counter
    logic [MREG_W-1:0]  r_merge;
    logic [LAT_W-1:0]   r_settle;

    logic               busy;
    logic               in_take;
    logic               fire;
    logic               cfg_wr;
    logic [MERGE_W-1:0] merge_eff;
    logic               out_free;
    logic [DIM_W-1:0]   cur_height;
    logic [DIM_W-1:0]   cur_width;
    t_geom              geom;

    // effective merge size clamped to 1..MAX_MERGE
    always_comb begin
        if (r_merge == '0) begin
            merge_eff = MERGE_W'(1);
        end else if (32'(r_merge) > MAX_MERGE) begin
            merge_eff = MERGE_W'(MAX_MERGE);
        end else begin
            merge_eff = MERGE_W'(r_merge);
        end
    end

    // geometry is stale while the settle counter runs
    assign busy = (r_settle != '0);

    // a load needs no result slot, a request does
    assign fire    = r_in_vld && !busy && ((r_in.cmd == CMD_LOAD) || out_free);
    assign in_take = !r_in_vld || fire;
    assign cfg_wr  = i_cfg_valid && o_cfg_ready;

    assign o_in_stall  = !in_take;
    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_merge  <= MREG_W'(2);
            r_settle <= '0;
        end else begin
            if (i_in_valid && in_take) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end

            if (cfg_wr) begin
                r_merge <= i_cfg_data;
            end

            // restart the settle window on any geometry change
            if (cfg_wr || (fire && (r_in.cmd == CMD_LOAD))) begin
                r_settle <= LAT_W'(GEOM_LAT);
            end else if (busy) begin
                r_settle <= r_settle - LAT_W'(1);
            end
        end
    end

    // payload of the input register
    always_ff @(posedge i_clk) begin
        if (i_in_valid && in_take) begin
            r_in <= i_in_data;
        end
    end

    mbp_geom #(
        .MAX_MERGE (MAX_MERGE)
    ) u_geom (
        .i_clk    (i_clk),
        .i_height (cur_height),
        .i_width  (cur_width),
        .i_merge  (merge_eff),
        .o_geom   (geom)
    );

    mbp_walk #(
        .MAX_MERGE (MAX_MERGE)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in),
        .i_merge     (merge_eff),
        .i_geom      (geom),
        .i_out_stall (i_out_stall),
        .o_height    (cur_height),
        .o_width     (cur_width),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // a merge size write opens the settle window
    a_cfg_settles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> busy)
        else $error("merge size write did not hold off requests");

    // a processed load opens the settle window
    a_load_settles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_in.cmd == CMD_LOAD)) |=> busy)
        else $error("load did not hold off requests");

    // a waiting item is kept while the geometry settles
    a_hold_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && busy) |=> r_in_vld)
        else $error("input item lost during geometry settle");

endmodule

>>> hdl/mbp_geom.sv
// ----------------------------------------------------------------------------
// mbp_geom
// pipelined block geometry: whole blocks per axis, block region and grid size
// ----------------------------------------------------------------------------
module mbp_geom #(
    parameter int  MAX_MERGE = 8,
    localparam int MERGE_W   = $clog2(MAX_MERGE + 1)
) (
    input  logic                 i_clk,
    input  logic [mbp_pkg::DIM_W-1:0] i_height,
    input  logic [mbp_pkg::DIM_W-1:0] i_width,
    input  logic [MERGE_W-1:0]   i_merge,
    output mbp_pkg::t_geom       o_geom
);
    import mbp_pkg::*;

    // floor(x / m) as (x * ceil(2^SH / m)) >> SH, exact for x < 2^DIM_W
    localparam int SH     = DIM_W + MERGE_W;
    localparam int RCP_W  = SH + 1;
    localparam int PROD_W = DIM_W + RCP_W;
    localparam int TAB_N  = 2 ** MERGE_W;

    logic [RCP_W-1:0]  recip_tab [TAB_N];
    logic [RCP_W-1:0]  recip;
    logic [PROD_W-1:0] prod_h;
    logic [PROD_W-1:0] prod_w;

    logic [DIM_W-1:0]  r_qh;
    logic [DIM_W-1:0]  r_qw;
    logic [AREA_W-1:0] r_grid_a;
    logic [DIM_W-1:0]  r_hm;
    logic [DIM_W-1:0]  r_wm;
    logic [DIM_W-1:0]  r_qw_b;
    logic [AREA_W-1:0] r_grid_b;
    logic [AREA_W-1:0] r_region;
    logic [DIM_W-1:0]  r_qw_c;
    logic [AREA_W-1:0] r_grid_c;

    for (genvar k = 0; k < TAB_N; k++) begin : g_rcp
        localparam longint RK = (k == 0) ? 0 :
                                ((longint'(1) << SH) + k - 1) / ((k == 0) ? 1 : k);
        assign recip_tab[k] = RCP_W'(RK);
    end

    assign recip  = recip_tab[i_merge];
    assign prod_h = PROD_W'(i_height) * PROD_W'(recip);
    assign prod_w = PROD_W'(i_width)  * PROD_W'(recip);

    // stage a: quotients and grid area
    always_ff @(posedge i_clk) begin
        r_qh     <= prod_h[SH +: DIM_W];
        r_qw     <= prod_w[SH +: DIM_W];
        r_grid_a <= AREA_W'(i_height) * AREA_W'(i_width);
    end

    // stage b: block-covered extent per axis
    always_ff @(posedge i_clk) begin
        r_hm     <= DIM_W'(r_qh * DIM_W'(i_merge));
        r_wm     <= DIM_W'(r_qw * DIM_W'(i_merge));
        r_qw_b   <= r_qw;
        r_grid_b <= r_grid_a;
    end

    // stage c: block region area
    always_ff @(posedge i_clk) begin
        r_region <= AREA_W'(r_hm) * AREA_W'(r_wm);
        r_qw_c   <= r_qw_b;
        r_grid_c <= r_grid_b;
    end

    assign o_geom.nwb    = r_qw_c;
    assign o_geom.region = r_region;
    assign o_geom.grid   = r_grid_c;

endmodule

>>> hdl/mbp_walk.sv
// ----------------------------------------------------------------------------
// mbp_walk
// image state, nested block counters and the result register
// ----------------------------------------------------------------------------
module mbp_walk #(
    parameter int  MAX_MERGE = 8,
    localparam int MERGE_W   = $clog2(MAX_MERGE + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  mbp_pkg::t_in_item         i_item,
    input  logic [MERGE_W-1:0]        i_merge,
    input  mbp_pkg::t_geom            i_geom,
    input  logic                      i_out_stall,
    output logic [mbp_pkg::DIM_W-1:0] o_height,
    output logic [mbp_pkg::DIM_W-1:0] o_width,
    output logic                      o_out_free,
    output logic                      o_out_valid,
    output mbp_pkg::t_out_item        o_out_data
);
    import mbp_pkg::*;

    localparam int IN_W  = (MAX_MERGE > 1) ? $clog2(MAX_MERGE) : 1;
    localparam int RC_W  = POS_W + MERGE_W + 1;
    localparam int CMP_W = DIM_W + 1;

    logic [DIM_W-1:0]  r_frames,    n_frames;
    logic [DIM_W-1:0]  r_height,    n_height;
    logic [DIM_W-1:0]  r_width,     n_width;
    logic [DIM_W-1:0]  r_frame_cnt, n_frame_cnt;
    logic [POS_W-1:0]  r_block_row, n_block_row;
    logic [POS_W-1:0]  r_block_col, n_block_col;
    logic [IN_W-1:0]   r_inner_row, n_inner_row;
    logic [IN_W-1:0]   r_inner_col, n_inner_col;
    logic [FLAT_W-1:0] r_flat,      n_flat;
    logic              r_active,    n_active;
    logic              r_out_vld,   n_out_vld;
    t_out_item         r_out,       n_out;

    logic              do_load;
    logic              do_next;
    logic [DIM_W-1:0]  sat_h;
    logic [DIM_W-1:0]  sat_w;
    logic [RC_W-1:0]   row_full;
    logic [RC_W-1:0]   col_full;
    logic              in_region;
    logic [AREA_W-1:0] flat_inc;
    logic              frame_end;
    logic              image_end;
    logic [MERGE_W-1:0] col_inc;
    logic [MERGE_W-1:0] row_inc;
    logic [POS_W:0]    bcol_inc;

    assign do_load = i_fire && (i_item.cmd == CMD_LOAD);
    assign do_next = i_fire && (i_item.cmd == CMD_NEXT) && r_active;

    assign sat_h = (32'(i_item.img_height) > MAX_GRID) ? DIM_W'(MAX_GRID)
                                                        : i_item.img_height;
    assign sat_w = (32'(i_item.img_width) > MAX_GRID)  ? DIM_W'(MAX_GRID)
                                                        : i_item.img_width;

    assign row_full  = RC_W'(r_block_row) * RC_W'(i_merge) + RC_W'(r_inner_row);
    assign col_full  = RC_W'(r_block_col) * RC_W'(i_merge) + RC_W'(r_inner_col);
    assign in_region = AREA_W'(r_flat) < i_geom.region;

    assign flat_inc  = AREA_W'(r_flat) + AREA_W'(1);
    assign frame_end = flat_inc >= i_geom.grid;
    assign image_end = (CMP_W'(r_frame_cnt) + CMP_W'(1)) >= CMP_W'(r_frames);

    assign col_inc  = MERGE_W'(r_inner_col) + MERGE_W'(1);
    assign row_inc  = MERGE_W'(r_inner_row) + MERGE_W'(1);
    assign bcol_inc = {1'b0, r_block_col} + (POS_W + 1)'(1);

    always_comb begin
        n_frames    = r_frames;
        n_height    = r_height;
        n_width     = r_width;
        n_frame_cnt = r_frame_cnt;
        n_block_row = r_block_row;
        n_block_col = r_block_col;
        n_inner_row = r_inner_row;
        n_inner_col = r_inner_col;
        n_flat      = r_flat;
        n_active    = r_active;
        n_out_vld   = r_out_vld && i_out_stall;
        n_out       = r_out;

        if (do_load) begin
            n_frames    = i_item.img_frames;
            n_height    = sat_h;
            n_width     = sat_w;
            n_frame_cnt = '0;
            n_block_row = '0;
            n_block_col = '0;
            n_inner_row = '0;
            n_inner_col = '0;
            n_flat      = '0;
            n_active    = (i_item.img_frames != '0) && (sat_h != '0) && (sat_w != '0);
        end else if (do_next) begin
            n_out_vld           = 1'b1;
            n_out.pos_row       = in_region ? row_full[POS_W-1:0] : '0;
            n_out.pos_col       = in_region ? col_full[POS_W-1:0] : '0;
            n_out.last_of_image = 1'b0;

            if (frame_end) begin
                if (image_end) begin
                    n_out.last_of_image = 1'b1;
                    n_active            = 1'b0;
                end else begin
                    n_frame_cnt = r_frame_cnt + DIM_W'(1);
                end
                n_block_row = '0;
                n_block_col = '0;
                n_inner_row = '0;
                n_inner_col = '0;
                n_flat      = '0;
            end else begin
                n_flat = flat_inc[FLAT_W-1:0];
                if (col_inc >= i_merge) begin
                    n_inner_col = '0;
                    if (row_inc >= i_merge) begin
                        n_inner_row = '0;
                        if (CMP_W'(bcol_inc) >= CMP_W'(i_geom.nwb)) begin
                            n_block_col = '0;
                            n_block_row = r_block_row + POS_W'(1);
                        end else begin
                            n_block_col = bcol_inc[POS_W-1:0];
                        end
                    end else begin
                        n_inner_row = IN_W'(row_inc);
                    end
                end else begin
                    n_inner_col = IN_W'(col_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames    <= '0;
            r_height    <= '0;
            r_width     <= '0;
            r_frame_cnt <= '0;
            r_block_row <= '0;
            r_block_col <= '0;
            r_inner_row <= '0;
            r_inner_col <= '0;
            r_flat      <= '0;
            r_active    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_frames    <= n_frames;
            r_height    <= n_height;
            r_width     <= n_width;
            r_frame_cnt <= n_frame_cnt;
            r_block_row <= n_block_row;
            r_block_col <= n_block_col;
            r_inner_row <= n_inner_row;
            r_inner_col <= n_inner_col;
            r_flat      <= n_flat;
            r_active    <= n_active;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_height    = r_height;
    assign o_width     = r_width;
    assign o_out_free  = !r_out_vld || !i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // the marked position ends the image
    a_last_ends_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_next && frame_end && image_end) |=> !r_active)
        else $error("walk still active after last position");

    // a new result only appears after a served request
    a_result_from_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(i_fire))
        else $error("result without a served request");

    // position inside the block stays below the largest merge size
    a_inner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_inner_col) < MAX_MERGE) && (32'(r_inner_row) < MAX_MERGE))
        else $error("inner block counter out of range");

endmodule

>>> test/tb_merge_block_position_ids_top.sv
// ----------------------------------------------------------------------------
// tb_merge_block_position_ids_top
// self-checking bench for the block-walk position id generator
// ----------------------------------------------------------------------------
// Drives load and next items through the stall handshake, writes merge_size
// only while no position is outstanding, and keeps its own model of the
// block walk to predict every (row, col, last) transfer. Starts with a short
// directed run, then three random phases with different idle mixes on the
// input and output channels.
// ----------------------------------------------------------------------------
module tb_merge_block_position_ids_top;
    import mbp_pkg::*;

    // models the walk and holds the positions still owed by the block
    class block_walk_tracker;
        int unsigned       merge_cap;
        logic [MREG_W-1:0] merge_reg;
        logic [DIM_W-1:0]  frames, height, width, frame_cnt;
        logic [POS_W-1:0]  blk_row, blk_col;
        logic [3:0]        in_row, in_col;
        logic [FLAT_W-1:0] flat;
        bit                active;
        t_out_item         pending_pos[$];
        int                fail_count;

        function new(int unsigned cap);
            merge_cap  = cap;
            merge_reg  = 4'd2;  // reset value of the register
            frames     = '0;
            height     = '0;
            width      = '0;
            frame_cnt  = '0;
            active     = 1'b0;
            fail_count = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            blk_row = '0;
            blk_col = '0;
            in_row  = '0;
            in_col  = '0;
            flat    = '0;
        endfunction

        function void set_merge(logic [MREG_W-1:0] value);
            merge_reg = value;
        endfunction

        // returns 1 when the item did something (load or served request)
        function bit take_item(t_in_item it);
            int unsigned m, nhb, nwb, region, grid_sz, row, col, nc, nr, bc;
            t_out_item   res;
            if (it.cmd == CMD_LOAD) begin
                frames    = it.img_frames;
                height    = (it.img_height > MAX_GRID) ? DIM_W'(MAX_GRID) : it.img_height;
                width     = (it.img_width > MAX_GRID) ? DIM_W'(MAX_GRID) : it.img_width;
                frame_cnt = '0;
                restart_frame();
                active = (frames != 0) && (height != 0) && (width != 0);
                return 1'b1;
            end
            if (!active) return 1'b0;

            m = (merge_reg == 0) ? 1 : merge_reg;
            if (m > merge_cap) m = merge_cap;
            nhb     = height / m;
            nwb     = width / m;
            region  = nhb * nwb * m * m;
            grid_sz = height * width;

            // positions past the whole blocks come out as zero
            row = 0;
            col = 0;
            res.last_of_image = 1'b0;
            if (flat < region) begin
                row = blk_row * m + in_row;
                col = blk_col * m + in_col;
            end

            if (flat + 1 >= grid_sz) begin
                if (frame_cnt + 1 >= frames) begin
                    res.last_of_image = 1'b1;
                    active = 1'b0;
                end else begin
                    frame_cnt = frame_cnt + 1'b1;
                end
                restart_frame();
            end else begin
                flat = flat + 1'b1;
                nc = in_col + 1;
                nr = in_row;
                bc = blk_col;
                if (nc >= m) begin
                    nc = 0;
                    nr++;
                    if (nr >= m) begin
                        nr = 0;
                        bc++;
                        if (bc >= nwb) begin
                            bc = 0;
                            blk_row = blk_row + 1'b1;
                        end
                    end
                end
                in_col  = nc[3:0];
                in_row  = nr[3:0];
                blk_col = bc[POS_W-1:0];
            end

            res.pos_row = row[POS_W-1:0];
            res.pos_col = col[POS_W-1:0];
            pending_pos.push_back(res);
            return 1'b1;
        endfunction

        function void check_pos(t_out_item got);
            t_out_item want;
            if (pending_pos.size() == 0) begin
                $error("unexpected position transfer: row %0d col %0d last %0b",
                       got.pos_row, got.pos_col, got.last_of_image);
                fail_count++;
                return;
            end
            want = pending_pos.pop_front();
            if (got.pos_row !== want.pos_row) begin
                $error("pos_row: expected %0d, got %0d", want.pos_row, got.pos_row);
                fail_count++;
            end
            if (got.pos_col !== want.pos_col) begin
                $error("pos_col: expected %0d, got %0d", want.pos_col, got.pos_col);
                fail_count++;
            end
            if (got.last_of_image !== want.last_of_image) begin
                $error("last_of_image: expected %0b, got %0b",
                       want.last_of_image, got.last_of_image);
                fail_count++;
            end
        endfunction

        function void flag_leftovers();
            if (pending_pos.size() != 0) begin
                $error("%0d expected positions never arrived", pending_pos.size());
                fail_count += pending_pos.size();
            end
        endfunction
    endclass

    localparam int MERGE_CAP     = 8;
    localparam int HALF_PERIOD   = 5;
    // covers the result path and the geometry settle, with margin
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int PHASE_ITEMS   = 340;     // three phases, at least 1020 items
    localparam int RUN_LIMIT     = 5000000; // far above a slow run

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    t_in_item          in_data   = '0;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [MREG_W-1:0] cfg_data  = '0;
    logic              in_stall;
    logic              out_valid;
    t_out_item         out_data;
    logic              cfg_ready;

    // idle mix, percent of cycles; the stall driver reads recv_idle_pct every cycle
    int send_idle_pct = 34;
    int recv_idle_pct = 68;
    // items that loaded an image or were served, ignored requests left out
    int items_used    = 0;

    block_walk_tracker walk;

    merge_block_position_ids_top #(
        .MAX_MERGE (MERGE_CAP)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // receiver side: random backpressure, changed on the falling edge
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // every result transfer is checked against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            walk.check_pos(out_data);
        end
    end

    // hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT);
        $display("tb_merge_block_position_ids_top: FAIL");
        $finish;
    end

    function automatic t_in_item make_load(input int f, input int h, input int w);
        t_in_item it;
        it.cmd        = CMD_LOAD;
        it.img_frames = DIM_W'(f);
        it.img_height = DIM_W'(h);
        it.img_width  = DIM_W'(w);
        return it;
    endfunction

    // dimension fields of a next item are don't-care, so fill them with noise
    function automatic t_in_item make_next();
        t_in_item  it;
        bit [63:0] r;
        r      = {$urandom, $urandom};
        it     = r[$bits(t_in_item)-1:0];
        it.cmd = CMD_NEXT;
        return it;
    endfunction

    function automatic logic [MREG_W-1:0] pick_merge();
        if ($urandom_range(3) != 0) return MREG_W'($urandom_range(MERGE_CAP, 1));
        return MREG_W'($urandom_range(15));
    endfunction

    // called on a falling edge; returns on the falling edge after the transfer
    // with valid still high, so back-to-back items need no extra edge
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (walk.take_item(it)) items_used++;
        @(negedge clk);
    endtask

    task automatic park_input();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    // register write only once every owed position has been delivered and
    // the pipeline behind ignored items and loads has had time to empty
    task automatic write_merge(input logic [MREG_W-1:0] value);
        park_input();
        while (walk.pending_pos.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        walk.set_merge(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int sidle, input int ridle,
                             input logic [MREG_W-1:0] first_merge, input int goal);
        int stop_at, pick, f, h, w, total, part;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        write_merge(first_merge);
        stop_at = items_used + goal;
        while (items_used < stop_at) begin
            if ($urandom_range(99) < 20) write_merge(pick_merge());
            pick  = $urandom_range(99);
            f     = ($urandom_range(3) == 0) ? 2 : 1;
            h     = $urandom_range(10, 1);
            w     = $urandom_range(10, 1);
            total = f * h * w;
            if (pick < 70) begin
                // complete walk, sometimes with stray requests after the end
                send_item(make_load(f, h, w));
                repeat (total + $urandom_range(2)) send_item(make_next());
            end else if (pick < 82) begin
                // cut-off walk; half the time merge_size changes mid-image
                // and the walk is finished under the new size
                send_item(make_load(f, h, w));
                part = $urandom_range(total - 1);
                repeat (part) send_item(make_next());
                if ($urandom_range(1) == 1) begin
                    write_merge(pick_merge());
                    repeat (total - part) send_item(make_next());
                end
            end else if (pick < 90) begin
                // any 11-bit dimensions, a few requests, then a restart
                t_in_item it;
                it     = make_next();
                it.cmd = CMD_LOAD;
                send_item(it);
                repeat ($urandom_range(4)) send_item(make_next());
            end else if (pick < 95) begin
                // empty image: a zero dimension leaves the block idle
                case ($urandom_range(2))
                    0: begin
                        f = 0;
                    end
                    1: begin
                        h = 0;
                    end
                    default: begin
                        w = 0;
                    end
                endcase
                send_item(make_load(f, h, w));
                repeat ($urandom_range(2, 1)) send_item(make_next());
            end else begin
                // huge grid near or past saturation, only its first positions
                send_item(make_load($urandom_range(2047, 1), $urandom_range(2047, 1000),
                                    $urandom_range(2047, 1000)));
                repeat ($urandom_range(6, 1)) send_item(make_next());
            end
        end
    endtask

    initial begin
        int guard;
        walk = new(MERGE_CAP);

        // synchronous reset
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: request with nothing loaded
        send_item(make_next());
        // two frames of a 2x3 grid at the reset merge size: one whole block,
        // two zero positions per frame, last marked at the end of frame two
        send_item(make_load(2, 2, 3));
        repeat (12) send_item(make_next());
        // request after the image has ended
        send_item(make_next());
        // all-ones dimensions saturate the grid
        send_item(make_load(2047, 2047, 2047));
        repeat (2) send_item(make_next());
        // load while an image is active restarts; zero frames stays idle
        send_item(make_load(0, 5, 5));
        send_item(make_next());
        // zero width stays idle as well
        send_item(make_load(1, 1, 0));
        // merge size zero behaves as one
        write_merge('0);
        send_item(make_load(1, 1, 2));
        repeat (2) send_item(make_next());

        // random phases: sender-light, receiver-light, then no idling
        run_phase(34, 68, 4'd15, PHASE_ITEMS);
        run_phase(68, 34, MREG_W'(MERGE_CAP), PHASE_ITEMS);
        run_phase(0, 0, 4'd1, PHASE_ITEMS);

        // drain, then give the pipeline time to show any extra transfer
        park_input();
        guard = 0;
        while (walk.pending_pos.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        walk.flag_leftovers();

        if (walk.fail_count == 0) begin
            $display("tb_merge_block_position_ids_top: PASS");
        end else begin
            $display("tb_merge_block_position_ids_top: FAIL");
        end
        $finish;
    end

endmodule
